FILE: src/lidar_point_georeference_core_assert.svh
// Assertion macros shared by the lidar georeference RTL.
// No dependencies; include by bare file name.
`ifndef LIDAR_POINT_GEOREFERENCE_CORE_ASSERT_SVH
`define LIDAR_POINT_GEOREFERENCE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpg: next-cycle check failed");

`endif

FILE: src/lpg_pkg.sv
// Types and constants for the lidar point georeference pipeline.
// No dependencies; imported by lpg_rot and the top level.
package lpg_pkg;

  localparam int COEF_FRAC_BITS = 16;

  localparam int PIN_W  = 24;
  localparam int COEF_W = 18;
  localparam int MAP_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Vehicle-frame width: rotated point after rounding plus mounting offset.
  localparam int PT_W   = (43 - COEF_FRAC_BITS > 26) ? (43 - COEF_FRAC_BITS) : 26;
  localparam int PROD_W = PT_W + COEF_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - COEF_FRAC_BITS;
  localparam int VSUM_W = ((RND_W > PT_W) ? RND_W : PT_W) + 1;
  localparam int FIN_W  = ((RND_W > MAP_W) ? RND_W : MAP_W) + 1;

  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic [COEF_W-1:0] COEF_ONE_RST = 18'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOUNT_COS   = 3'd0,
    REG_MOUNT_SIN   = 3'd1,
    REG_MOUNT_OFS_X = 3'd2,
    REG_MOUNT_OFS_Y = 3'd3,
    REG_HEAD_COS    = 3'd4,
    REG_HEAD_SIN    = 3'd5,
    REG_BASE_X      = 3'd6,
    REG_BASE_Y      = 3'd7
  } lpg_reg_t;

  // Load enables for the two register stages of one rotation unit.
  typedef struct packed {
    logic en_mul;
    logic en_rnd;
  } lpg_ctl_t;

endpackage

FILE: src/lpg_rot.sv
// Two-stage rotation unit: four products, then rounded sum and difference.
// Depends on lpg_pkg.
module lpg_rot
  import lpg_pkg::*;
(
  input  logic                     clk,
  input  lpg_ctl_t                 ctl,
  input  logic                     neg_sum,
  input  logic signed [PT_W-1:0]   p,
  input  logic signed [PT_W-1:0]   q,
  input  logic signed [COEF_W-1:0] c,
  input  logic signed [COEF_W-1:0] s,
  output logic signed [RND_W-1:0]  sum_rnd,
  output logic signed [RND_W-1:0]  dif_rnd
);

  logic signed [PROD_W-1:0] pc_r, qs_r, qc_r, ps_r;
  logic signed [RND_W-1:0]  sum_r, dif_r;
  logic signed [ACC_W-1:0]  sum_raw, sum_acc, dif_acc, sum_nxt, dif_nxt;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      pc_r <= PROD_W'(p) * PROD_W'(c);
      qs_r <= PROD_W'(q) * PROD_W'(s);
      qc_r <= PROD_W'(q) * PROD_W'(c);
      ps_r <= PROD_W'(p) * PROD_W'(s);
    end
  end

  // Add half an LSB, then floor: round to nearest, ties up.
  always_comb begin
    sum_raw = ACC_W'(pc_r) + ACC_W'(qs_r);
    sum_acc = neg_sum ? -sum_raw : sum_raw;
    dif_acc = ACC_W'(qc_r) - ACC_W'(ps_r);
    sum_nxt = sum_acc + $signed(RND_HALF);
    dif_nxt = dif_acc + $signed(RND_HALF);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_rnd) begin
      sum_r <= sum_nxt[ACC_W-1:COEF_FRAC_BITS];
      dif_r <= dif_nxt[ACC_W-1:COEF_FRAC_BITS];
    end
  end

  assign sum_rnd = sum_r;
  assign dif_rnd = dif_r;

endmodule

FILE: src/lidar_point_georeference_core.sv
// Lidar point georeference core: six-stage pipeline from lidar frame to map frame.
// Depends on lpg_pkg, lpg_rot and lidar_point_georeference_core_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one point word: x, y, z in mm and
//   a last-in-scan marker. Output channel (out_valid/out_ready) returns one map
//   word per point, in order: map x/y (saturated, with clipped flag), z and the
//   scan-end marker copied through.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes one of the
//   eight registers selected by cfg_index; write only while the pipe is empty.
//   Throughput is one word per cycle while out_ready stays high; a word
//   passes through the six register stages in order (mount products, mount
//   rounding, mounting offset add, heading products, heading rounding, base
//   add and saturation).
//   When the receiver stalls, words pile up stage by stage: any empty stage
//   still loads, so in_ready drops only once all six stages hold words.
//   Reset (rst_n low, synchronous) empties the pipe and loads the registers
//   with identity rotations and zero offsets.
`include "lidar_point_georeference_core_assert.svh"
module lidar_point_georeference_core
  import lpg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [PIN_W-1:0]      in_point_x,
  input  logic signed [PIN_W-1:0]      in_point_y,
  input  logic signed [PIN_W-1:0]      in_point_z,
  input  logic                         in_last_in_scan,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [MAP_W-1:0]      out_map_x,
  output logic signed [MAP_W-1:0]      out_map_y,
  output logic signed [PIN_W-1:0]      out_map_z,
  output logic                         out_scan_end,
  output logic                         out_clipped
);

  localparam int NSTG = 6;

  localparam logic signed [FIN_W-1:0] SAT_MAX =
    $signed({{(FIN_W-MAP_W+1){1'b0}}, {(MAP_W-1){1'b1}}});
  localparam logic signed [FIN_W-1:0] SAT_MIN =
    $signed({{(FIN_W-MAP_W+1){1'b1}}, {(MAP_W-1){1'b0}}});
  localparam logic signed [MAP_W-1:0] MAP_MAX = $signed({1'b0, {(MAP_W-1){1'b1}}});
  localparam logic signed [MAP_W-1:0] MAP_MIN = $signed({1'b1, {(MAP_W-1){1'b0}}});

  // Configuration registers.
  logic signed [COEF_W-1:0] mc_r, ms_r, hc_r, hs_r;
  logic signed [PIN_W-1:0]  ox_r, oy_r;
  logic signed [MAP_W-1:0]  bx_r, by_r;

  // Pipeline control and sideband.
  logic [NSTG-1:0]    v_r;
  logic [NSTG:0]      en;
  logic [PIN_W-1:0]   z_r    [NSTG];
  logic [NSTG-1:0]    last_r;

  lpg_ctl_t ctl_a, ctl_b;

  logic signed [PT_W-1:0]   px, py, vx_r, vy_r;
  logic signed [RND_W-1:0]  a_sum, a_dif, b_sum, b_dif;
  logic signed [VSUM_W-1:0] vx_nxt, vy_nxt;
  logic signed [FIN_W-1:0]  fx, fy;
  logic signed [MAP_W-1:0]  map_x_r, map_y_r, map_x_nxt, map_y_nxt;
  logic                     clip_r, clip_nxt;

  // Accept config writes every cycle; truncate data to the register width.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r <= COEF_ONE_RST;
      ms_r <= '0;
      ox_r <= '0;
      oy_r <= '0;
      hc_r <= COEF_ONE_RST;
      hs_r <= '0;
      bx_r <= '0;
      by_r <= '0;
    end else if (cfg_valid) begin
      case (lpg_reg_t'(cfg_index))
        REG_MOUNT_COS:   mc_r <= cfg_data[COEF_W-1:0];
        REG_MOUNT_SIN:   ms_r <= cfg_data[COEF_W-1:0];
        REG_MOUNT_OFS_X: ox_r <= cfg_data[PIN_W-1:0];
        REG_MOUNT_OFS_Y: oy_r <= cfg_data[PIN_W-1:0];
        REG_HEAD_COS:    hc_r <= cfg_data[COEF_W-1:0];
        REG_HEAD_SIN:    hs_r <= cfg_data[COEF_W-1:0];
        REG_BASE_X:      bx_r <= cfg_data[MAP_W-1:0];
        REG_BASE_Y:      by_r <= cfg_data[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its word moves on this cycle.
  always_comb begin
    en[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Carry z and the scan marker alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      z_r[0]    <= in_point_z;
      last_r[0] <= in_last_in_scan;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        z_r[k]    <= z_r[k-1];
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // Mounting rotation: vx from (y*mc - x*ms), vy from -(x*mc + y*ms).
  assign px = {{(PT_W-PIN_W){in_point_x[PIN_W-1]}}, in_point_x};
  assign py = {{(PT_W-PIN_W){in_point_y[PIN_W-1]}}, in_point_y};
  assign ctl_a = '{en_mul: en[0], en_rnd: en[1]};

  lpg_rot u_rot_mount (
    .clk     (clk),
    .ctl     (ctl_a),
    .neg_sum (1'b1),
    .p       (px),
    .q       (py),
    .c       (mc_r),
    .s       (ms_r),
    .sum_rnd (a_sum),
    .dif_rnd (a_dif)
  );

  // Add the mounting offset to get vehicle-frame coordinates.
  always_comb begin
    vx_nxt = VSUM_W'(a_dif) + VSUM_W'(ox_r);
    vy_nxt = VSUM_W'(a_sum) + VSUM_W'(oy_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      vx_r <= vx_nxt[PT_W-1:0];
      vy_r <= vy_nxt[PT_W-1:0];
    end
  end

  // Heading rotation: X from (vx*hc + vy*hs), Y from (vy*hc - vx*hs).
  assign ctl_b = '{en_mul: en[3], en_rnd: en[4]};

  lpg_rot u_rot_head (
    .clk     (clk),
    .ctl     (ctl_b),
    .neg_sum (1'b0),
    .p       (vx_r),
    .q       (vy_r),
    .c       (hc_r),
    .s       (hs_r),
    .sum_rnd (b_sum),
    .dif_rnd (b_dif)
  );

  // Add the base offset, then clamp to the 32-bit map range.
  always_comb begin
    fx = FIN_W'(bx_r) + FIN_W'(b_sum);
    fy = FIN_W'(by_r) + FIN_W'(b_dif);
    clip_nxt = 1'b0;
    if (fx > SAT_MAX) begin
      map_x_nxt = MAP_MAX;
      clip_nxt  = 1'b1;
    end else if (fx < SAT_MIN) begin
      map_x_nxt = MAP_MIN;
      clip_nxt  = 1'b1;
    end else begin
      map_x_nxt = fx[MAP_W-1:0];
    end
    if (fy > SAT_MAX) begin
      map_y_nxt = MAP_MAX;
      clip_nxt  = 1'b1;
    end else if (fy < SAT_MIN) begin
      map_y_nxt = MAP_MIN;
      clip_nxt  = 1'b1;
    end else begin
      map_y_nxt = fy[MAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      map_x_r <= map_x_nxt;
      map_y_r <= map_y_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign out_valid    = v_r[NSTG-1];
  assign out_map_x    = map_x_r;
  assign out_map_y    = map_y_r;
  assign out_map_z    = z_r[NSTG-1];
  assign out_scan_end = last_r[NSTG-1];
  assign out_clipped  = clip_r;

  // An empty first stage must never block the input.
  `LPG_ASSERT_IMPL(a_in_ready_empty, clk, rst_n, !v_r[0], in_ready)
  // An accepted word occupies the first stage next cycle.
  `LPG_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && in_ready, v_r[0])
  // A word blocked in the heading-rounding stage is not dropped.
  `LPG_ASSERT_NEXT(a_hold_stage, clk, rst_n, v_r[4] && !en[5], v_r[4])
  // The clipped flag comes only with a coordinate at a bound.
  `LPG_ASSERT_IMPL(a_clip_bound, clk, rst_n, out_valid && out_clipped,
    out_map_x == MAP_MAX || out_map_x == MAP_MIN ||
    out_map_y == MAP_MAX || out_map_y == MAP_MIN)

endmodule
